### hw/rtl/block_linear_ramp_generator_macros.svh
// Assertion macros for the linear ramp generator.
`ifndef BLOCK_LINEAR_RAMP_GENERATOR_MACROS_SVH
`define BLOCK_LINEAR_RAMP_GENERATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BRG_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define BRG_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/brg_pkg.sv
// Shared widths, codes and types of the linear ramp generator.
`timescale 1ns / 1ps
package brg_pkg;
	localparam int LEVEL_W   = 32;
	localparam int MS_W      = 16;
	localparam int TPM_W     = 24;
	localparam int LOG2_W    = 3;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;
	localparam int DIV_W     = LEVEL_W + 1;
	localparam int FRAC_W    = 16;

	localparam int MAX_BLOCK_DEF = 64;

	localparam logic [TPM_W-1:0]  TPM_RESET  = 24'd49152;
	localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 2'd1;

	// Status of a bit-serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} srl_stat_t;
endpackage

### hw/rtl/brg_channels.sv
// Valid/ready channel interfaces: commands, samples and configuration writes.
`timescale 1ns / 1ps
interface brg_cmd_if import brg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [LEVEL_W-1:0] goal_level;
	logic [MS_W-1:0]           ramp_ms;
	modport source (output valid, op, goal_level, ramp_ms, input ready);
	modport sink (input valid, op, goal_level, ramp_ms, output ready);
endinterface

interface brg_smp_if import brg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] level;
	logic                      last;
	modport source (output valid, level, last, input ready);
	modport sink (input valid, level, last, output ready);
endinterface

interface brg_cfg_if import brg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/brg_mul.sv
// Bit-serial shift-add multiplier for ramp time times ticks per millisecond.
`timescale 1ns / 1ps
module brg_mul import brg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MS_W-1:0]  ms,
	input  logic [TPM_W-1:0] tpm,
	output srl_stat_t        stat,
	output logic [TPM_W-1:0] ticks
);
	localparam int ACC_W = MS_W + TPM_W;
	localparam int CNT_W = $clog2(MS_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] acc_q;
	logic [TPM_W-1:0] tpm_q;
	logic [TPM_W:0]   sum;

	// One multiplier bit per cycle: add the multiplicand into the high half, then shift right.
	assign sum = {1'b0, acc_q[ACC_W-1:MS_W]} + (acc_q[0] ? {1'b0, tpm_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(MS_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MS_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{TPM_W{1'b0}}, ms};
			tpm_q <= tpm;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MS_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	// The Q24.16 product keeps its integer part only.
	assign ticks = acc_q[ACC_W-1:FRAC_W];
endmodule

### hw/rtl/brg_div.sv
// Bit-serial restoring divider for the per-tick step, truncating toward zero.
`timescale 1ns / 1ps
module brg_div import brg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	input  logic               neg,
	input  logic [TPM_W-1:0]   divisor,
	output srl_stat_t          stat,
	output logic [LEVEL_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TPM_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [TPM_W-1:0] dvs_q;
	logic             neg_q;
	logic [TPM_W:0]   trial;
	logic [TPM_W:0]   trial_sub;
	logic             fits;

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(DIV_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[TPM_W-1:0] : trial[TPM_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (~quo_q[LEVEL_W-1:0] + LEVEL_W'(1)) : quo_q[LEVEL_W-1:0];
endmodule

### hw/rtl/block_linear_ramp_generator.sv
// Top level of the linear ramp generator: command decode, retarget sequencing, sample output.
`timescale 1ns / 1ps
`include "block_linear_ramp_generator_macros.svh"
// Usage. Commands arrive as items on the cmd channel: set target (goal and ramp time),
// stop, and tick. Each tick produces one block of 2^block_log2 samples on the samples
// channel, the block size capped at MAX_BLOCK, with last marking the final sample.
// Set target and stop produce no items.
// A tick without a pending retarget starts its block on the next cycle and then puts
// out one sample per cycle while the receiver keeps taking them.
// The first tick after a set target with a nonzero ramp time first runs the serial
// multiplier, one ramp-time bit per cycle, and then the serial divider, one quotient
// bit per cycle, before its block starts.
// cmd.ready is high only while no command is being worked on; the next command is taken
// as soon as the final sample of a block sits in the output register.
// A stalled receiver simply holds the output register; samples wait and nothing is lost.
// The cfg channel is always ready; writes belong to idle periods. Index 0 is ticks per
// millisecond, index 1 is block_log2, other indexes are ignored.
// Reset sets level, goal and steps to zero and loads the register defaults.
module block_linear_ramp_generator import brg_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	brg_cmd_if.sink  cmd,
	brg_smp_if.source samples,
	brg_cfg_if.sink  cfg
);
	localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
	localparam int MAX_LOG2 = CNT_W - 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [TPM_W-1:0]    tpm_q;
	logic [LOG2_W-1:0]   log2_q;
	logic [LEVEL_W-1:0]  goal_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [LEVEL_W-1:0]  step_tick_q;
	logic [LEVEL_W-1:0]  step_smp_q;
	logic [TPM_W-1:0]    ticks_left_q;
	logic                pend_q;
	logic [MS_W-1:0]     pend_ms_q;

	// Sample generator of the block in flight.
	logic [LEVEL_W-1:0]  acc_q;
	logic [LEVEL_W-1:0]  inc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic                out_last_q;

	logic [LOG2_W-1:0]   eff_log2;
	logic [CNT_W-1:0]    n_samp;
	logic [CNT_W-1:0]    cnt_nxt;
	logic                load;
	logic                cmd_acc;

	srl_stat_t           mul_stat;
	srl_stat_t           div_stat;
	logic [TPM_W-1:0]    mul_ticks;
	logic [TPM_W-1:0]    ticks_new;
	logic [LEVEL_W-1:0]  div_quo;
	logic [LEVEL_W-1:0]  smp_new;
	logic [DIV_W-1:0]    diff;
	logic [DIV_W-1:0]    diff_mag;
	logic                mul_start;
	logic                div_start;

	// Block size is block_log2 capped so that the block never exceeds MAX_BLOCK.
	assign eff_log2 = (log2_q > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : log2_q;
	assign n_samp   = CNT_W'(1) << eff_log2;
	assign cnt_nxt  = cnt_q + CNT_W'(1);
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || samples.ready);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	// A tick count of zero is raised to one.
	assign ticks_new = (mul_ticks == '0) ? TPM_W'(1) : mul_ticks;

	// The level difference is exact in 33 bits; the divider works on its magnitude.
	assign diff      = {goal_q[LEVEL_W-1], goal_q} - {level_q[LEVEL_W-1], level_q};
	assign diff_mag  = diff[DIV_W-1] ? (~diff + DIV_W'(1)) : diff;
	assign smp_new   = $unsigned($signed(div_quo) >>> eff_log2);

	assign mul_start = cmd_acc && (cmd.op == OP_TICK) && pend_q;
	assign div_start = (state_q == ST_MUL) && mul_stat.done;

	brg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.ms     (pend_ms_q),
		.tpm    (tpm_q),
		.stat   (mul_stat),
		.ticks  (mul_ticks)
	);

	brg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_mag),
		.neg      (diff[DIV_W-1]),
		.divisor  (ticks_new),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tpm_q        <= TPM_RESET;
			log2_q       <= LOG2_RESET;
			goal_q       <= '0;
			level_q      <= '0;
			step_tick_q  <= '0;
			step_smp_q   <= '0;
			ticks_left_q <= '0;
			pend_q       <= 1'b0;
			pend_ms_q    <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_TICKS_PER_MS: tpm_q  <= cfg.data[TPM_W-1:0];
					CFG_BLOCK_LOG2:   log2_q <= cfg.data[LOG2_W-1:0];
					default: ;
				endcase
			end

			// The output register fills on a load and empties when the receiver takes it.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						unique case (cmd.op)
							OP_SET: begin
								goal_q <= cmd.goal_level;
								if (cmd.ramp_ms == '0) begin
									level_q      <= cmd.goal_level;
									ticks_left_q <= '0;
									pend_q       <= 1'b0;
								end else begin
									pend_q    <= 1'b1;
									pend_ms_q <= cmd.ramp_ms;
								end
							end
							OP_STOP: begin
								goal_q       <= level_q;
								ticks_left_q <= '0;
								pend_q       <= 1'b0;
							end
							OP_TICK: begin
								if (pend_q) begin
									state_q <= ST_MUL;
								end else begin
									// Launch the block with the stored ramp.
									cnt_q   <= '0;
									state_q <= ST_EMIT;
									if (ticks_left_q != '0) begin
										level_q      <= level_q + step_tick_q;
										ticks_left_q <= ticks_left_q - TPM_W'(1);
									end else begin
										level_q <= goal_q;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						ticks_left_q <= ticks_new;
						state_q      <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						// The new ramp always has at least one tick, so this block ramps.
						step_tick_q  <= div_quo;
						step_smp_q   <= smp_new;
						pend_q       <= 1'b0;
						level_q      <= level_q + div_quo;
						ticks_left_q <= ticks_left_q - TPM_W'(1);
						cnt_q        <= '0;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						cnt_q <= cnt_nxt;
						if (cnt_nxt == n_samp) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample datapath: the start value and increment are captured when a block launches.
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.op == OP_TICK) && !pend_q) begin
			if (ticks_left_q != '0) begin
				acc_q <= level_q;
				inc_q <= step_smp_q;
			end else begin
				acc_q <= goal_q;
				inc_q <= '0;
			end
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			acc_q <= level_q;
			inc_q <= smp_new;
		end else if (load) begin
			acc_q <= acc_q + inc_q;
		end
		if (load) begin
			out_level_q <= acc_q;
			out_last_q  <= (cnt_nxt == n_samp);
		end
	end

	assign samples.valid = out_valid_q;
	assign samples.level = out_level_q;
	assign samples.last  = out_last_q;

	// Commands are taken only while both serial units are quiet.
	`BRG_ASSERT_NOW(a_ready_units_idle,
		!cmd.ready || (!mul_stat.busy && !div_stat.busy),
		"command taken while an arithmetic unit is busy")
	// The multiplier result is handed straight to the divider.
	`BRG_ASSERT_NEXT(a_mul_then_div,
		(state_q == ST_MUL) && mul_stat.done,
		div_stat.busy && (state_q == ST_DIV),
		"divider did not start after the multiplier")
	// The sample count never runs past the block size.
	`BRG_ASSERT_NOW(a_cnt_in_block,
		(state_q != ST_EMIT) || (cnt_q < n_samp),
		"sample count past the block size")
endmodule

### dv/tb.sv
// Self-checking testbench of the linear ramp generator: directed command table, then random ramps.
`timescale 1ns / 1ps
module tb;
	import brg_pkg::*;

	// Clock and run control.
	localparam int PERIOD          = 20;
	localparam int RESET_CYCLES    = 8;
	localparam int IDLE_LIMIT      = 3000;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 80;
	localparam int N_PHASES        = 6;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int N_OPENING       = 24;

	// The one op code the block must ignore, and the two register indexes it has no register
	// behind. The package names only the codes that the block acts on.
	localparam logic [OP_W-1:0]      OP_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [LEVEL_W-1:0] goal;
		logic [MS_W-1:0]    ms;
	} ramp_cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} ramp_sample_t;

	// A row of the opening table. Where pinned is set, every sample of the block the command
	// causes must equal pinned_level; otherwise the levels come from the predictor.
	typedef struct packed {
		ramp_cmd_t          cmd;
		logic               pinned;
		logic [LEVEL_W-1:0] pinned_level;
	} opening_row_t;

	logic clk;
	logic arst_n;

	brg_cmd_if cmd_ch ();
	brg_smp_if smp_ch ();
	brg_cfg_if cfg_ch ();

	block_linear_ramp_generator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.samples (smp_ch),
		.cfg     (cfg_ch)
	);

	// Predictor state: a copy of the registers and of the ramp state of the block.
	logic [TPM_W-1:0]   reg_ticks_per_ms;
	logic [LOG2_W-1:0]  reg_block_log2;
	logic [LEVEL_W-1:0] ramp_goal;
	logic [LEVEL_W-1:0] ramp_level;
	logic [LEVEL_W-1:0] ramp_step_tick;
	logic [LEVEL_W-1:0] ramp_step_sample;
	logic [TPM_W-1:0]   ramp_ticks_left;
	logic               ramp_pending;
	logic [MS_W-1:0]    ramp_pending_ms;

	// Samples still owed by the block, oldest first.
	ramp_sample_t samples_due[$];

	int  mismatches;
	bit  eager_sender;
	bit  hold_go;
	logic holding;

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// The effective block size is capped at MAX_BLOCK: a block_log2 of 7 acts as 6.
	function automatic int unsigned block_shift();
		int unsigned l;
		l = reg_block_log2;
		while (l > 0 && (1 << l) > MAX_BLOCK_DEF)
			l--;
		return l;
	endfunction

	// The first tick after a set target with a nonzero ramp time recomputes the ramp. The
	// tick count is a Q24.16 product truncated to whole ticks and never below one; the
	// difference is formed in 33 bits and divided with truncation toward zero.
	task automatic ramp_retarget();
		logic [39:0] prod;
		logic [39:0] span;
		longint      diff;
		longint      quot;
		prod = 40'(ramp_pending_ms) * 40'(reg_ticks_per_ms);
		span = prod >> FRAC_W;
		if (span == 40'd0)
			span = 40'd1;
		if (span > 40'hFF_FFFF)
			span = 40'hFF_FFFF;
		ramp_ticks_left = span[TPM_W-1:0];
		diff = longint'($signed(ramp_goal)) - longint'($signed(ramp_level));
		quot = diff / longint'(span);
		ramp_step_tick = quot[LEVEL_W-1:0];
		// The arithmetic shift rounds toward minus infinity.
		ramp_step_sample = $signed(ramp_step_tick) >>> block_shift();
		ramp_pending = 1'b0;
	endtask

	// Applies one accepted command to the predictor and queues the samples it causes.
	task automatic ramp_predict(input ramp_cmd_t c, input logic pinned,
			input logic [LEVEL_W-1:0] pinned_level);
		int unsigned        n;
		logic [LEVEL_W-1:0] f;
		ramp_sample_t       s;
		case (c.op)
			OP_SET: begin
				ramp_goal = c.goal;
				if (c.ms == '0) begin
					// A zero ramp time jumps at once and drops any pending retarget.
					ramp_level = c.goal;
					ramp_ticks_left = '0;
					ramp_pending = 1'b0;
				end else begin
					ramp_pending = 1'b1;
					ramp_pending_ms = c.ms;
				end
			end
			OP_STOP: begin
				ramp_goal = ramp_level;
				ramp_ticks_left = '0;
				ramp_pending = 1'b0;
			end
			OP_TICK: begin
				if (ramp_pending)
					ramp_retarget();
				n = 1 << block_shift();
				f = ramp_level;
				for (int unsigned i = 0; i < n; i++) begin
					s.level = (ramp_ticks_left != '0) ? f : ramp_goal;
					s.last = (i + 1 == n);
					if (pinned)
						s.level = pinned_level;
					samples_due.push_back(s);
					f = f + ramp_step_sample;
				end
				if (ramp_ticks_left != '0) begin
					ramp_level = ramp_level + ramp_step_tick;
					ramp_ticks_left = ramp_ticks_left - 1'b1;
				end else begin
					ramp_level = ramp_goal;
				end
			end
			default: begin
				// The unused op code changes nothing.
			end
		endcase
	endtask

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int unsigned cmd_gap();
		int unsigned r;
		if (eager_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one command and waits for it to be taken. Valid stays high from one item
	// to the next when there is no gap, so it is assigned once per time step.
	task automatic send_cmd(input ramp_cmd_t c, input logic pinned,
			input logic [LEVEL_W-1:0] pinned_level);
		int unsigned gap;
		gap = cmd_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= c.op;
		cmd_ch.goal_level <= c.goal;
		cmd_ch.ramp_ms <= c.ms;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		ramp_predict(c, pinned, pinned_level);
	endtask

	// Writes one register and mirrors the write in the predictor. The caller lowers valid.
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_TICKS_PER_MS: reg_ticks_per_ms = data[TPM_W-1:0];
			CFG_BLOCK_LOG2:   reg_block_log2 = data[LOG2_W-1:0];
			default: begin
				// Writes to indexes without a register are dropped.
			end
		endcase
	endtask

	// Waits until every owed sample has arrived, then lets the block finish any set or stop
	// that produced nothing.
	task automatic drain();
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A ramp time: often a jump, mostly a few milliseconds so that ramps end within a few
	// ticks, sometimes long, and sometimes any 16-bit value.
	function automatic logic [MS_W-1:0] pick_ramp_ms();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return '0;
		if (r < 80)
			return MS_W'($urandom_range(1, 12));
		if (r < 92)
			return MS_W'($urandom_range(13, 300));
		return MS_W'($urandom);
	endfunction

	// A goal: any level, or one close to the present level so that steps are small and
	// the rounding of the per-sample step shows.
	function automatic logic [LEVEL_W-1:0] pick_goal();
		if ($urandom_range(0, 99) < 70)
			return $urandom;
		return ramp_level + LEVEL_W'(int'($urandom_range(0, 4000)) - 2000);
	endfunction

	// Random part of a phase. Most of it is a set target followed by a run of ticks; the
	// rest is stops, a set target with no tick after it, and the ignored op code. Unused
	// fields of a command carry random bits. The ignored op does not count toward budget.
	task automatic ramp_random(input int budget);
		int          made;
		int unsigned r;
		int unsigned k;
		ramp_cmd_t   c;
		made = 0;
		while (made < budget) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				c = '{OP_NONE, $urandom, MS_W'($urandom)};
				send_cmd(c, 1'b0, '0);
			end else if (r < 12) begin
				c = '{OP_STOP, $urandom, MS_W'($urandom)};
				send_cmd(c, 1'b0, '0);
				made++;
			end else if (r < 16) begin
				c = '{OP_SET, pick_goal(), pick_ramp_ms()};
				send_cmd(c, 1'b0, '0);
				made++;
			end else begin
				c = '{OP_SET, pick_goal(), pick_ramp_ms()};
				send_cmd(c, 1'b0, '0);
				k = $urandom_range(1, 6);
				for (int unsigned i = 0; i < k; i++) begin
					c = '{OP_TICK, $urandom, MS_W'($urandom)};
					send_cmd(c, 1'b0, '0);
				end
				made += 1 + k;
			end
		end
	endtask

	// Receiver: takes samples, checks each against the oldest owed one, and stalls at
	// random. Runs of ready or stall have random lengths, mostly short; some long runs of
	// ready give stretches without stalls. While holding is set, it stalls outright.
	initial begin
		int unsigned  run;
		int unsigned  r;
		bit           want;
		ramp_sample_t due;
		run = 0;
		want = 1'b1;
		smp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (smp_ch.valid && smp_ch.ready) begin
				if (samples_due.size() == 0) begin
					$display("%0t ns: unexpected sample, expected none, got level %h last %0b",
						$time, smp_ch.level, smp_ch.last);
					mismatches++;
				end else begin
					due = samples_due.pop_front();
					if (smp_ch.level !== due.level || smp_ch.last !== due.last) begin
						$display("%0t ns: sample mismatch, expected level %h last %0b, got level %h last %0b",
							$time, due.level, due.last, smp_ch.level, smp_ch.last);
						mismatches++;
					end
				end
			end
			if (run == 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					want = 1'b1;
					run = $urandom_range(100, 300);
				end else if (r < 70) begin
					want = 1'b1;
					run = $urandom_range(1, 6);
				end else if (r < 95) begin
					want = 1'b0;
					run = $urandom_range(1, 4);
				end else begin
					want = 1'b0;
					run = $urandom_range(20, 60);
				end
			end
			run--;
			smp_ch.ready <= want && !holding;
		end
	end

	// Back pressure: once the random part starts, the receiver holds off for a long
	// stretch while commands keep coming, so the output register fills and the block
	// stops taking commands.
	initial begin
		holding <= 1'b0;
		wait (hold_go);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	// Watchdog: ends the run if nothing moves on any channel for too long. The limit
	// covers the long hold-off, a long sender gap and a retarget together.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (smp_ch.valid && smp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		opening_row_t opening [N_OPENING];
		opening = '{
			// After reset the level is zero.
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h0000_0000},
			// Jumps to the largest and the smallest level.
			'{'{OP_SET,  32'h7FFF_FFFF, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h7FFF_FFFF},
			'{'{OP_SET,  32'h8000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'hFFFF_FFFF, 16'hFFFF},  1'b1, 32'h8000_0000},
			// A full-scale ramp whose tick count truncates to zero and is raised to one;
			// the 33-bit difference fits, but the 32-bit step does not and wraps.
			'{'{OP_SET,  32'h7FFF_FFFF, 16'd1},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h7FFF_FFFF},
			// The longest ramp time, downward, then a stop that freezes the level.
			'{'{OP_SET,  32'h8000_0000, 16'hFFFF},  1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_STOP, 32'h5555_5555, 16'h5555},  1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			// The unused op code must leave everything as it is.
			'{'{OP_NONE, 32'hAAAA_AAAA, 16'hAAAA},  1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			// A three-tick ramp to 1.0, then two ticks that sit on the goal.
			'{'{OP_SET,  32'h0100_0000, 16'd4},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h0100_0000},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h0100_0000},
			// A jump cancels a retarget that is still pending.
			'{'{OP_SET,  32'h0000_0000, 16'd2},     1'b0, 32'h0},
			'{'{OP_SET,  32'h0080_0000, 16'd0},     1'b0, 32'h0},
			'{'{OP_TICK, 32'h0000_0000, 16'd0},     1'b1, 32'h0080_0000}
		};

		mismatches = 0;
		eager_sender = 1'b0;
		hold_go = 1'b0;
		reg_ticks_per_ms = TPM_RESET;
		reg_block_log2 = LOG2_RESET;
		ramp_goal = '0;
		ramp_level = '0;
		ramp_step_tick = '0;
		ramp_step_sample = '0;
		ramp_ticks_left = '0;
		ramp_pending = 1'b0;
		ramp_pending_ms = '0;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op <= OP_TICK;
		cmd_ch.goal_level <= '0;
		cmd_ch.ramp_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_TICKS_PER_MS;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The opening table runs with the register defaults.
		for (int i = 0; i < N_OPENING; i++)
			send_cmd(opening[i].cmd, opening[i].pinned, opening[i].pinned_level);

		hold_go = 1'b1;
		ramp_random(ITEMS_PER_PHASE - N_OPENING);

		// Each later phase starts from an idle block with new register values: the
		// extremes of both registers, an oversized block, writes to indexes without a
		// register, random values, and default ticks per millisecond with block_log2 at 1.
		for (int ph = 1; ph < N_PHASES; ph++) begin
			cmd_ch.valid <= 1'b0;
			drain();
			case (ph)
				1: begin
					cfg_put(CFG_TICKS_PER_MS, 24'd0);
					cfg_put(CFG_BLOCK_LOG2, 24'd0);
				end
				2: begin
					cfg_put(CFG_TICKS_PER_MS, 24'hFF_FFFF);
					cfg_put(CFG_BLOCK_LOG2, 24'd7);
				end
				3: begin
					cfg_put(CFG_TICKS_PER_MS, 24'd65536);
					cfg_put(CFG_BLOCK_LOG2, 24'd3);
					cfg_put(CFG_SPARE_2, CFG_DAT_W'($urandom));
					cfg_put(CFG_SPARE_3, CFG_DAT_W'($urandom));
				end
				4: begin
					cfg_put(CFG_TICKS_PER_MS, CFG_DAT_W'($urandom_range(0, 200000)));
					cfg_put(CFG_BLOCK_LOG2, CFG_DAT_W'($urandom));
				end
				default: begin
					cfg_put(CFG_TICKS_PER_MS, CFG_DAT_W'(TPM_RESET));
					cfg_put(CFG_BLOCK_LOG2, 24'd1);
				end
			endcase
			cfg_ch.valid <= 1'b0;
			// One phase offers commands back to back.
			eager_sender = (ph == 3);
			ramp_random(ITEMS_PER_PHASE);
		end

		cmd_ch.valid <= 1'b0;
		drain();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
